// File: sv/ssort_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Shell sort engine.
// No dependencies.
package ssort_pkg;

    localparam int GAP_W     = 7;
    // gap / 3 as (gap * 43) >> 7, exact for gaps up to 64
    localparam int DIV3_MUL  = 43;
    localparam int DIV3_SHR  = 7;

    typedef logic [GAP_W-1:0] t_gap7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_GAP,
        ST_RD_I,
        ST_RD_IG,
        ST_CMP,
        ST_PUT,
        ST_OUT_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic gap_step;
        logic rd_i;
        logic rd_ig;
        logic mv;
        logic put;
        logic out_rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic less;
        logic jm_ge_gap;
        logic inext_lt_n;
        logic ng_lt_n;
        logic ng_gt1;
        logic gap_gt1;
        logic out_last;
    } t_sts;

    function automatic t_gap7 div3(input t_gap7 g);
        logic [GAP_W+5:0] prod;
        prod = {6'd0, g} * (GAP_W+6)'(DIV3_MUL);
        return t_gap7'(prod >> DIV3_SHR);
    endfunction

endpackage

// File: sv/ssort_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for load, Shell sort passes and drain.
// Depends on ssort_pkg; drives ssort_dpath through t_cmd.
module ssort_ctrl import ssort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_last,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_last) n_state = ST_INIT;
            end
            ST_INIT:  n_state = ST_GAP;
            ST_GAP: begin
                if (i_sts.ng_lt_n)     n_state = ST_RD_I;
                else if (!i_sts.ng_gt1) n_state = ST_OUT_RD;
            end
            ST_RD_I:  n_state = ST_RD_IG;
            ST_RD_IG: n_state = ST_CMP;
            ST_CMP: begin
                if (!(i_sts.less && i_sts.jm_ge_gap)) n_state = ST_PUT;
            end
            ST_PUT: begin
                if (i_sts.inext_lt_n)   n_state = ST_RD_I;
                else if (i_sts.gap_gt1) n_state = ST_GAP;
                else                    n_state = ST_OUT_RD;
            end
            ST_OUT_RD: n_state = ST_EMIT;
            ST_EMIT: begin
                n_state = i_sts.out_last ? ST_IDLE : ST_OUT_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:   o_cmd.load     = start;
            ST_INIT:   o_cmd.init     = 1'b1;
            ST_GAP:    o_cmd.gap_step = 1'b1;
            ST_RD_I:   o_cmd.rd_i     = 1'b1;
            ST_RD_IG:  o_cmd.rd_ig    = 1'b1;
            ST_CMP:    o_cmd.mv       = i_sts.less;
            ST_PUT:    o_cmd.put      = 1'b1;
            ST_OUT_RD: o_cmd.out_rd   = 1'b1;
            ST_EMIT:   o_cmd.emit     = 1'b1;
            default:   o_cmd          = '0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// File: sv/ssort_dpath.sv
`timescale 1ns / 1ps
// Element store, counters and compare logic of the Shell sort engine.
// Depends on ssort_pkg; commanded by ssort_ctrl.
module ssort_dpath import ssort_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_value,
    output t_sts               o_sts,
    output logic signed [31:0] o_value_res,
    output logic               o_last_res,
    output logic               o_overflow
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [31:0] mem [MAX_LEN];

    logic [CW-1:0] r_fill, n_fill;
    logic          r_dropped, n_dropped;
    logic [CW-1:0] r_gap, n_gap;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [31:0]   r_held;
    logic [31:0]   r_rdata;

    logic [CW-1:0] ng, jm, jmm, inext, igap;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    function automatic logic [CW-1:0] inext_fill(input logic [CW-1:0] f);
        return f + CW'(1);
    endfunction

    assign ng    = CW'(div3(GAP_W'(r_gap))) + CW'(1);
    assign jm    = r_j - r_gap;
    assign jmm   = jm - r_gap;
    assign inext = r_i + CW'(1);
    assign igap  = r_i - r_gap;

    assign o_sts.less       = $signed(r_held) < $signed(r_rdata);
    assign o_sts.jm_ge_gap  = (jm >= r_gap);
    assign o_sts.inext_lt_n = (inext < r_fill);
    assign o_sts.ng_lt_n    = (ng < r_fill);
    assign o_sts.ng_gt1     = (ng > CW'(1));
    assign o_sts.gap_gt1    = (r_gap > CW'(1));
    assign o_sts.out_last   = (r_k == r_fill - CW'(1));

    always_comb begin
        we    = 1'b0;
        waddr = r_j[AW-1:0];
        wdata = r_held;
        re    = 1'b0;
        raddr = r_k[AW-1:0];
        if (i_cmd.load) begin
            we    = (r_fill < CW'(MAX_LEN));
            waddr = r_fill[AW-1:0];
            wdata = i_value;
        end else if (i_cmd.mv) begin
            we    = 1'b1;
            wdata = r_rdata;
        end else if (i_cmd.put) begin
            we    = 1'b1;
        end
        if (i_cmd.rd_i) begin
            re    = 1'b1;
            raddr = r_i[AW-1:0];
        end else if (i_cmd.rd_ig) begin
            re    = 1'b1;
            raddr = igap[AW-1:0];
        end else if (i_cmd.mv) begin
            re    = o_sts.jm_ge_gap;
            raddr = jmm[AW-1:0];
        end else if (i_cmd.out_rd) begin
            re    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rdata <= mem[raddr];
        if (i_cmd.rd_ig) r_held <= r_rdata;
    end

    always_comb begin
        n_fill    = r_fill;
        n_dropped = r_dropped;
        n_gap     = r_gap;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        if (i_cmd.load) begin
            if (r_fill < CW'(MAX_LEN)) n_fill = inext_fill(r_fill);
            else                       n_dropped = 1'b1;
        end
        if (i_cmd.init) begin
            n_gap = r_fill;
            n_k   = '0;
        end
        if (i_cmd.gap_step) begin
            n_gap = ng;
            n_i   = ng;
        end
        if (i_cmd.rd_ig) n_j = r_i;
        if (i_cmd.mv)    n_j = jm;
        if (i_cmd.put)   n_i = inext;
        if (i_cmd.emit) begin
            n_k = r_k + CW'(1);
            if (o_sts.out_last) begin
                n_fill    = '0;
                n_dropped = 1'b0;
                n_gap     = '0;
                n_k       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_dropped <= 1'b0;
            r_gap     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
        end else begin
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
            r_gap     <= n_gap;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
        end
    end

    assign o_value_res = $signed(r_rdata);
    assign o_last_res  = i_cmd.emit & o_sts.out_last;
    assign o_overflow  = r_dropped;

endmodule

// File: sv/shell_sort_engine_unit.sv
`timescale 1ns / 1ps
// Shell sort engine: loads a set of signed 32-bit values, sorts, drains.
// Top level; depends on ssort_pkg, ssort_ctrl and ssort_dpath.
//
// Input: an item transfers on a rising edge with start high and busy low.
// Items without i_last are stored one per cycle (busy stays low). Past
// MAX_LEN items are dropped and o_overflow is raised for the whole set.
// The item with i_last closes the set; busy then rises for the sort and
// the drain.
// Sort: Shell passes, gap g -> g/3 + 1 down to 1, as gapped insertion over
// a single store with one write and one registered read port. Each insertion
// takes two reads, the first compare and the write-back, plus one move per
// element moved, and each pass one gap step; a set of 64 runs five passes.
// Output: sorted values, each read from the store and then put on o_value_res
// for one cycle with o_strobe high; o_last_res marks the final one. The receiver
// cannot stall; busy falls in the cycle after the final result.
// Reset: synchronous, active low; clears the set and returns to idle.
module shell_sort_engine_unit import ssort_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    output logic               o_strobe,
    output logic signed [31:0] o_value_res,
    output logic               o_last_res,
    output logic               o_overflow
);

    t_cmd cmd;
    t_sts sts;

    ssort_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ssort_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_sts       (sts),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    assign o_strobe = cmd.emit;

endmodule

// File: sv/ssort_chk.sv
`timescale 1ns / 1ps
// Port-level checks for the Shell sort engine, bound to the top level.
// Depends on shell_sort_engine_unit ports only.
module ssort_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last,
    input logic o_strobe,
    input logic o_last_res
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result strobe while idle");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !busy) else $error("busy after plain load");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> (busy && !o_strobe))
        else $error("closing transfer did not start sort");

    a_drain_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_res) |=> (busy && !o_strobe))
        else $error("results not spaced during drain");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_res) |=> !busy) else $error("busy after final result");

endmodule

bind shell_sort_engine_unit ssort_chk u_ssort_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_last     (i_last),
    .o_strobe   (o_strobe),
    .o_last_res (o_last_res)
);

// File: tb/shell_sort_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for shell_sort_engine_unit: queued sets of signed values,
// a local Shell sort prediction and a strobe-side checker of every sorted value.
// Depends on ssort_pkg and the shell_sort_engine_unit RTL.
module shell_sort_engine_unit_tb;
    import ssort_pkg::*;

    localparam int SET_CAP      = 64;
    localparam int CALM_FIRST   = 120;
    localparam int CALM_LAST    = 200;
    localparam int RANDOM_ITEMS = 280;
    localparam int QUIET_LIMIT  = 40000;
    localparam int TAIL_CYCLES  = 100;
    localparam int PRINT_CAP    = 50;

    typedef enum int {
        VAL_ANY,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_RISING,
        VAL_FALLING
    } t_flavour;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        bit                 wait_empty;
    } t_sort_item;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               overflow;
    } t_sorted_elem;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic signed [31:0] i_value = '0;
    logic               i_last  = 1'b0;
    logic               busy;
    logic               o_strobe;
    logic signed [31:0] o_value_res;
    logic               o_last_res;
    logic               o_overflow;

    t_sort_item   pending_items[$];
    t_sorted_elem expected_sorted[$];

    logic signed [31:0] set_store[SET_CAP];
    int                 set_fill    = 0;
    logic               set_dropped = 1'b0;

    int mismatches      = 0;
    int n_transfers     = 0;
    int n_results       = 0;
    int n_sets          = 0;
    int n_overflow_sets = 0;
    int quiet_cycles    = 0;
    int queued_items    = 0;

    shell_sort_engine_unit #(.MAX_LEN(SET_CAP)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_strobe   (o_strobe),
        .o_value_res(o_value_res),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic logic signed [31:0] pick_value(t_flavour flavour, int pos, int base);
        case (flavour)
            VAL_NARROW:  return 32'(int'($urandom_range(16)) - 8);
            VAL_RISING:  return 32'(base + pos * 3);
            VAL_FALLING: return 32'(base - pos * 3);
            VAL_EXTREME: begin
                case ($urandom_range(4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'sh0000_0000;
                    3:       return -32'sd1;
                    default: return $urandom;
                endcase
            end
            default:     return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic signed [31:0] v, input logic lst, input bit hold);
        t_sort_item it;
        it.value      = v;
        it.last       = lst;
        it.wait_empty = hold;
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic queue_set(input int len, input t_flavour flavour, input bit hold);
        int base;
        base = $urandom;
        for (int k = 0; k < len; k++) begin
            queue_item(pick_value(flavour, k, base), k == len - 1, hold && k == 0);
        end
    endtask

    // gapped insertion passes, gap -> gap/3 + 1 until the pass at gap 1
    task automatic close_set();
        logic signed [31:0] arr[SET_CAP];
        logic signed [31:0] held;
        t_sorted_elem       e;
        int                 gap;
        int                 j;
        arr = set_store;
        gap = set_fill;
        do begin
            gap = gap / 3 + 1;
            for (int i = gap; i < set_fill; i++) begin
                held = arr[i];
                j    = i;
                while (j >= gap && held < arr[j - gap]) begin
                    arr[j] = arr[j - gap];
                    j      = j - gap;
                end
                arr[j] = held;
            end
        end while (gap > 1);
        for (int k = 0; k < set_fill; k++) begin
            e.value    = arr[k];
            e.last     = (k == set_fill - 1);
            e.overflow = set_dropped;
            expected_sorted.push_back(e);
        end
        n_sets++;
        if (set_dropped) begin
            n_overflow_sets++;
        end
        set_fill    = 0;
        set_dropped = 1'b0;
    endtask

    task automatic take_item(input t_sort_item it);
        if (set_fill < SET_CAP) begin
            set_store[set_fill] = it.value;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (it.last) begin
            close_set();
        end
    endtask

    always @(posedge i_clk) begin
        bit accepted;
        bit present;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                take_item(pending_items.pop_front());
                n_transfers++;
            end
            if (!(start && !accepted)) begin
                present = 1'b0;
                if (pending_items.size() > 0) begin
                    if (pending_items[0].wait_empty && expected_sorted.size() > 0) begin
                        present = 1'b0;
                    end else if (n_transfers >= CALM_FIRST && n_transfers < CALM_LAST) begin
                        present = 1'b1;
                    end else begin
                        present = ($urandom_range(99) >= 38);
                    end
                end
                if (present) begin
                    start   <= 1'b1;
                    i_value <= pending_items[0].value;
                    i_last  <= pending_items[0].last;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted_elem e;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (expected_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d", o_value_res));
            end else begin
                e = expected_sorted.pop_front();
                if (o_value_res !== e.value) begin
                    report_mismatch($sformatf("value %0d, want %0d", o_value_res, e.value));
                end
                if (o_last_res !== e.last) begin
                    report_mismatch($sformatf("last_res %b, want %b", o_last_res, e.last));
                end
                if (o_overflow !== e.overflow) begin
                    report_mismatch($sformatf("overflow %b, want %b", o_overflow, e.overflow));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        t_flavour fl;

        // single element, then a pair at the extremes
        queue_item(32'sh0000_0000, 1'b1, 1'b0);
        queue_item(32'sh7fff_ffff, 1'b0, 1'b1);
        queue_item(32'sh8000_0000, 1'b1, 1'b0);
        // extremes and signs mixed
        queue_item(32'sh8000_0000, 1'b0, 1'b0);
        queue_item(32'sh7fff_ffff, 1'b0, 1'b0);
        queue_item(32'sh0000_0000, 1'b0, 1'b0);
        queue_item(-32'sd1,        1'b0, 1'b0);
        queue_item(32'sd1,         1'b0, 1'b0);
        queue_item(-32'sd2,        1'b1, 1'b0);
        // equal values
        queue_item(32'sd5,  1'b0, 1'b0);
        queue_item(32'sd5,  1'b0, 1'b0);
        queue_item(-32'sd3, 1'b0, 1'b0);
        queue_item(32'sd5,  1'b0, 1'b0);
        queue_item(-32'sd3, 1'b1, 1'b0);
        // reverse order
        queue_set(8, VAL_FALLING, 1'b0);

        // full set, full set closed by a dropped item, and a set well past capacity
        k = 0;
        while (queued_items < RANDOM_ITEMS + 22) begin
            fl = t_flavour'($urandom_range(4));
            case (k)
                3:       queue_set(SET_CAP,      fl, 1'b0);
                6:       queue_set(SET_CAP + 1,  VAL_ANY, 1'b1);
                9:       queue_set(SET_CAP + 6,  VAL_NARROW, 1'b0);
                default: queue_set($urandom_range(12, 1), fl, $urandom_range(9) == 0);
            endcase
            k++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (expected_sorted.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d input transfers in %0d sets, %0d with dropped items",
                 n_transfers, n_sets, n_overflow_sets);
        $display("run: %0d sorted results checked, %0d mismatches", n_results, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
